// ----- sv/ebpl_pkg.sv -----
// Shared types and constants for the escape byte patch list encoder.
// No dependencies; every other file imports this package.
package ebpl_pkg;

  localparam int unsigned LIST_DEPTH_DEF  = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_ESCAPE     = 2'd0;
  localparam logic [1:0] REG_CAPACITY   = 2'd1;
  localparam logic [1:0] REG_FIRST_SLOT = 2'd2;

  localparam logic [7:0] ESCAPE_RESET     = 8'hFE;
  localparam logic [8:0] CAPACITY_RESET   = 9'd256;
  localparam logic [7:0] FIRST_SLOT_RESET = 8'd0;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_PATCH = 1'b1;

  // Input actions
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  localparam logic [7:0] MARK_BYTE = 8'hFF;

  typedef struct packed {
    logic [7:0] escape_value;
    logic [8:0] list_capacity;
    logic [7:0] first_slot;
  } cfg_t;

  // One classified data byte: up to four results in fixed order
  typedef struct packed {
    logic       has_mark;
    logic [7:0] mark_val;
    logic [7:0] mark_slot;
    logic [7:0] data_val;
    logic       has_esc;
    logic [7:0] esc_val;
    logic [7:0] esc_slot;
    logic       has_term;
    logic [7:0] term_slot;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/ebpl_front.sv -----
// Front end: accepts input requests, tracks segment offset and cursor,
// and classifies each data byte into a queue entry. Uses ebpl_pkg.
module ebpl_front import ebpl_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  q_stat_t    q_stat,
  output logic       push,
  output entry_t     push_entry
);

  localparam int unsigned USABLE_MAX = (LIST_DEPTH < 256) ? LIST_DEPTH : 256;

  logic [7:0] seg_off_r, seg_off_nxt;
  logic [7:0] cursor_r, cursor_nxt;

  logic [8:0] n;
  logic       nz;
  logic [7:0] top, start_slot, seg_len, seg_base;
  logic       marker, is_esc, accept;
  logic [7:0] c1, c2;
  logic [23:0] p1, p2;

  // Returns {slot, value, next cursor}; saturate on the last usable slot
  function automatic logic [23:0] patch_step(input logic [7:0] cur,
                                             input logic [7:0] val,
                                             input logic [7:0] lim);
    logic [23:0] r;
    if (cur >= lim) begin
      r = {lim, MARK_BYTE, lim};
    end else begin
      r = {cur, val, cur + 8'd1};
    end
    return r;
  endfunction

  always_comb begin
    n          = (cfg.list_capacity > 9'(USABLE_MAX)) ? 9'(USABLE_MAX) : cfg.list_capacity;
    nz         = (n != 9'd0);
    top        = 8'(n - 9'd1);
    start_slot = !nz ? 8'd0 : ((cfg.first_slot < top) ? cfg.first_slot : top);
    seg_len    = (cfg.escape_value >= 8'd3) ? cfg.escape_value - 8'd2 : 8'd1;
    marker     = (seg_off_r >= seg_len);
    is_esc     = (in_byte == cfg.escape_value);
    seg_base   = marker ? 8'd0 : seg_off_r;

    p1 = patch_step(cursor_r, MARK_BYTE, top);
    c1 = marker ? p1[7:0] : cursor_r;
    p2 = patch_step(c1, seg_base + 8'd1, top);
    c2 = is_esc ? p2[7:0] : c1;

    push_entry.has_mark  = nz & marker;
    push_entry.mark_val  = p1[15:8];
    push_entry.mark_slot = p1[23:16];
    push_entry.data_val  = (nz & is_esc) ? MARK_BYTE : in_byte;
    push_entry.has_esc   = nz & is_esc;
    push_entry.esc_val   = p2[15:8];
    push_entry.esc_slot  = p2[23:16];
    push_entry.has_term  = nz & in_last;
    push_entry.term_slot = (c2 >= top) ? top : c2;
  end

  assign in_ready = !q_stat.full;
  assign accept   = in_valid & in_ready;
  assign push     = accept & (in_action == ACT_DATA);

  always_comb begin
    seg_off_nxt = seg_off_r;
    cursor_nxt  = cursor_r;
    if (accept) begin
      if (in_action == ACT_START) begin
        seg_off_nxt = 8'd0;
        cursor_nxt  = start_slot;
      end else if (nz) begin
        seg_off_nxt = seg_base + 8'd1;
        cursor_nxt  = c2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_off_r <= 8'd0;
      cursor_r  <= 8'd0;
    end else begin
      seg_off_r <= seg_off_nxt;
      cursor_r  <= cursor_nxt;
    end
  end

endmodule

// ----- sv/ebpl_queue.sv -----
// Short entry queue between front and back end, held in flip-flops.
// Uses ebpl_pkg for the entry and status types.
module ebpl_queue import ebpl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  entry_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push = push & !q_stat.full;
  assign do_pop  = pop & !q_stat.empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- sv/ebpl_back.sv -----
// Back end: walks the head queue entry one result per cycle into the
// output register while the output is not stalled. Uses ebpl_pkg.
module ebpl_back import ebpl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      head,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_data,
  output logic        out_last,
  output logic        out_kind
);

  logic        sent_mark_r, sent_mark_nxt;
  logic        sent_data_r, sent_data_nxt;
  logic        sent_esc_r, sent_esc_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] data_r, data_nxt;
  logic        last_r, last_nxt;
  logic        kind_r, kind_nxt;

  logic        load, sel_mark, sel_data, sel_esc, fin;

  always_comb begin
    load     = !q_stat.empty && (!valid_r || out_ready);
    sel_mark = head.has_mark && !sent_mark_r;
    sel_data = !sel_mark && !sent_data_r;
    sel_esc  = !sel_mark && !sel_data && head.has_esc && !sent_esc_r;
    // the terminator is the only remaining piece once the others are out
    fin      = (sel_data && !head.has_esc && !head.has_term) ||
               (sel_esc && !head.has_term) ||
               (!sel_mark && !sel_data && !sel_esc);

    if (sel_mark) begin
      data_nxt = {head.mark_slot, head.mark_val};
      kind_nxt = KIND_PATCH;
    end else if (sel_data) begin
      data_nxt = {8'd0, head.data_val};
      kind_nxt = KIND_DATA;
    end else if (sel_esc) begin
      data_nxt = {head.esc_slot, head.esc_val};
      kind_nxt = KIND_PATCH;
    end else begin
      data_nxt = {head.term_slot, MARK_BYTE};
      kind_nxt = KIND_PATCH;
    end
    last_nxt = fin;
    pop      = load && fin;

    sent_mark_nxt = sent_mark_r;
    sent_data_nxt = sent_data_r;
    sent_esc_nxt  = sent_esc_r;
    if (pop) begin
      sent_mark_nxt = 1'b0;
      sent_data_nxt = 1'b0;
      sent_esc_nxt  = 1'b0;
    end else if (load) begin
      sent_mark_nxt = sent_mark_r | sel_mark;
      sent_data_nxt = sent_data_r | sel_data;
      sent_esc_nxt  = sent_esc_r | sel_esc;
    end

    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_mark_r <= 1'b0;
      sent_data_r <= 1'b0;
      sent_esc_r  <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      sent_mark_r <= sent_mark_nxt;
      sent_data_r <= sent_data_nxt;
      sent_esc_r  <= sent_esc_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_kind  = kind_r;

endmodule

// ----- sv/escape_byte_patch_list_encoder_core.sv -----
// Top level of the escape byte patch list encoder: configuration registers,
// front end, entry queue and back end. Uses ebpl_pkg and the ebpl_* modules.
//
// The encoder takes one input request per cycle while the entry queue has
// room and emits one result per cycle while out_tready is high. A data byte
// yields one to four results (segment marker, the byte itself, the escape
// patch write, the terminator); the back end walks them into the output
// register one result per cycle. The entry queue of QUEUE_DEPTH bytes lets
// input keep flowing while extra patch writes drain. A start request
// produces no result. Each result passes through the entry queue and then
// the output register.
module escape_byte_patch_list_encoder_core import ebpl_pkg::*; #(
  parameter int unsigned LIST_DEPTH  = LIST_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] action
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value, [15:8] slot
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);

  cfg_t    cfg_r, cfg_nxt;
  q_stat_t q_stat;
  entry_t  push_entry, head;
  logic    push, pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ESCAPE:     cfg_nxt.escape_value  = cfg_wdata[7:0];
        REG_CAPACITY:   cfg_nxt.list_capacity = cfg_wdata;
        REG_FIRST_SLOT: cfg_nxt.first_slot    = cfg_wdata[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_value  <= ESCAPE_RESET;
      cfg_r.list_capacity <= CAPACITY_RESET;
      cfg_r.first_slot    <= FIRST_SLOT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ebpl_front #(.LIST_DEPTH(LIST_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_action  (in_tuser),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  ebpl_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  ebpl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_kind  (out_tuser)
  );

  // Data results never carry a slot
  a_data_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_DATA) |-> (out_tdata[15:8] == 8'd0))
    else $error("data result with nonzero slot");

  // A data byte that is not the final result is followed at once by a patch write
  a_patch_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == KIND_DATA && !out_tlast)
      |=> (out_tvalid && out_tuser == KIND_PATCH))
    else $error("missing patch write after data byte");

  // Input is taken only while the queue has room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !q_stat.full)
    else $error("input accepted with full queue");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for escape_byte_patch_list_encoder_core: directed corner cases, then
// random buffers under several register settings, checked by an in-bench encoder.
// Depends on ebpl_pkg and the encoder RTL only.
module tb_top import ebpl_pkg::*; ();

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [7:0] slot;
    logic       eor;
  } link_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [8:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] data_byte
  logic        in_tuser;   // [0] action
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] value, [15:8] slot
  logic        out_tuser;  // [0] kind
  logic        out_tlast;

  logic        steady;
  int unsigned mismatch_count;

  // Encoder state as the bench sees it
  logic [7:0] escape_byte;
  logic [8:0] capacity;
  logic [7:0] start_slot_cfg;
  logic [7:0] seg_offset;
  logic [7:0] cursor;
  link_result_t predicted_out_q[$];

  escape_byte_patch_list_encoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 33);
  end

  function automatic int unsigned list_size();
    int unsigned n;
    n = capacity;
    if (n > LIST_DEPTH_DEF) n = LIST_DEPTH_DEF;
    if (n > 256) n = 256;
    return n;
  endfunction

  function automatic logic [7:0] start_slot();
    int unsigned n;
    n = list_size();
    if (n == 0) return 8'd0;
    return (start_slot_cfg < n - 1) ? start_slot_cfg : 8'(n - 1);
  endfunction

  function automatic void reset_encoder();
    escape_byte    = ESCAPE_RESET;
    capacity       = CAPACITY_RESET;
    start_slot_cfg = FIRST_SLOT_RESET;
    seg_offset     = '0;
    cursor         = start_slot();
  endfunction

  function automatic void add_result(logic kind, logic [7:0] value, logic [7:0] slot);
    predicted_out_q.push_back('{kind, value, slot, 1'b0});
  endfunction

  // Saturate at the last usable slot: write the mark there and hold the cursor
  function automatic void add_patch(logic [7:0] value, int unsigned n);
    logic [7:0] top;
    top = 8'(n - 1);
    if (cursor >= top) begin
      cursor = top;
      add_result(KIND_PATCH, MARK_BYTE, top);
    end else begin
      add_result(KIND_PATCH, value, cursor);
      cursor = cursor + 8'd1;
    end
  endfunction

  function automatic void encode_request(logic act, logic [7:0] data, logic lst);
    int unsigned n;
    int unsigned seg_len;
    link_result_t tail;
    n = list_size();
    if (act == ACT_START) begin
      seg_offset = '0;
      cursor     = start_slot();
      return;
    end
    if (n == 0) begin
      add_result(KIND_DATA, data, 8'd0);
    end else begin
      seg_len = (escape_byte >= 3) ? escape_byte - 2 : 1;
      if (seg_offset >= seg_len) begin
        seg_offset = '0;
        add_patch(MARK_BYTE, n);
      end
      if (data == escape_byte) begin
        add_result(KIND_DATA, MARK_BYTE, 8'd0);
        add_patch(seg_offset + 8'd1, n);
      end else begin
        add_result(KIND_DATA, data, 8'd0);
      end
      seg_offset = seg_offset + 8'd1;
      // terminator clamps a stale cursor but never moves it
      if (lst) add_result(KIND_PATCH, MARK_BYTE, (cursor < n - 1) ? cursor : 8'(n - 1));
    end
    tail = predicted_out_q.pop_back();
    tail.eor = 1'b1;
    predicted_out_q.push_back(tail);
  endfunction

  // Sample at the falling edge; everything is driven at the rising edge
  always @(negedge clk) begin : check_out
    link_result_t want;
    link_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[7:0], out_tdata[15:8], out_tlast};
      if (predicted_out_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result at %0t: kind %0d value %h slot %0d last %0d",
                   $time, got.kind, got.value, got.slot, got.eor);
      end else begin
        want = predicted_out_q.pop_front();
        if (got.kind !== want.kind || got.value !== want.value ||
            got.slot !== want.slot || got.eor !== want.eor) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch %0t exp/act: kind %0d/%0d value %h/%h slot %0d/%0d last %0d/%0d",
                     $time, want.kind, got.kind, want.value, got.value,
                     want.slot, got.slot, want.eor, got.eor);
        end
      end
    end
  end

  task automatic send_request(input logic act, input logic [7:0] data, input logic lst);
    logic taken;
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    in_tlast  <= lst;
    do begin
      @(negedge clk);
      taken = in_tready;
      if (taken) encode_request(act, data, lst);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (predicted_out_q.size() != 0) @(posedge clk);
    // start requests leave nothing to wait on; cover the pipeline
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ESCAPE:     escape_byte = val[7:0];
      REG_CAPACITY:   capacity = val;
      REG_FIRST_SLOT: start_slot_cfg = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [7:0] esc, input logic [8:0] cap,
                               input logic [7:0] first);
    wait_drained();
    write_reg(REG_ESCAPE, {1'b0, esc});
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_FIRST_SLOT, {1'b0, first});
    cfg_we <= 1'b0;
  endtask

  // Reset values, cursor straight from reset, escape hit, start with junk fields
  task automatic test_reset_defaults();
    send_request(ACT_DATA, 8'h00, 1'b0);
    send_request(ACT_DATA, 8'hFF, 1'b0);
    send_request(ACT_DATA, 8'hFE, 1'b0);
    send_request(ACT_DATA, 8'h55, 1'b1);
    send_request(ACT_START, 8'hAA, 1'b1);
  endtask

  // Escape below three: one-byte segments, marker before every byte after the first
  task automatic test_small_escape();
    set_registers(8'd2, 9'd256, 8'd0);
    send_request(ACT_START, 8'h00, 1'b0);
    send_request(ACT_DATA, 8'h02, 1'b0);
    send_request(ACT_DATA, 8'h01, 1'b0);
    send_request(ACT_DATA, 8'h02, 1'b1);
  endtask

  task automatic test_zero_capacity();
    set_registers(8'd254, 9'd0, 8'd7);
    send_request(ACT_START, 8'h00, 1'b0);
    send_request(ACT_DATA, 8'hFE, 1'b0);
    send_request(ACT_DATA, 8'h80, 1'b1);
  endtask

  // Two slots, first slot clamped onto the last one: every patch saturates
  task automatic test_full_list();
    set_registers(8'd5, 9'd2, 8'd255);
    send_request(ACT_START, 8'hFF, 1'b0);
    send_request(ACT_DATA, 8'h05, 1'b0);
    send_request(ACT_DATA, 8'h05, 1'b0);
    send_request(ACT_DATA, 8'h01, 1'b1);
  endtask

  // Shrink the list mid-buffer, then keep going past the last byte
  task automatic test_stale_cursor();
    set_registers(8'd7, 9'd256, 8'd10);
    send_request(ACT_START, 8'h00, 1'b0);
    send_request(ACT_DATA, 8'h07, 1'b0);
    send_request(ACT_DATA, 8'h07, 1'b0);
    send_request(ACT_DATA, 8'h07, 1'b0);
    set_registers(8'd7, 9'd4, 8'd10);
    send_request(ACT_DATA, 8'h07, 1'b0);
    send_request(ACT_DATA, 8'h00, 1'b1);
    send_request(ACT_DATA, 8'h07, 1'b0);
  endtask

  // Mostly whole buffers with escape-heavy content; the rest is loose requests
  task automatic test_random_buffers(input logic [7:0] esc, input logic [8:0] cap,
                                     input logic [7:0] first, input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    set_registers(esc, cap, first);
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(24, 70) : $urandom_range(1, 24);
        send_request(ACT_START, 8'($urandom), 1'($urandom));
        for (int unsigned i = 0; i < len; i++)
          send_request(ACT_DATA, ($urandom_range(3) == 0) ? esc : 8'($urandom),
                       i == len - 1);
        sent += len + 1;
      end else begin
        send_request(($urandom_range(3) != 0) ? ACT_DATA : ACT_START, 8'($urandom),
                     1'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_addr       = REG_ESCAPE;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = ACT_START;
    in_tlast       = 1'b0;
    out_tready     = 1'b0;
    steady         = 1'b0;
    mismatch_count = 0;
    reset_encoder();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_small_escape();
    test_zero_capacity();
    test_full_list();
    test_stale_cursor();

    test_random_buffers(8'd254, 9'd256, 8'd0, 24);
    test_random_buffers(8'd3, 9'd256, 8'd0, 24);
    test_random_buffers(8'd255, 9'd256, 8'd255, 24);
    steady <= 1'b1;
    test_random_buffers(8'd5, 9'd8, 8'd2, 24);
    steady <= 1'b0;
    test_random_buffers(8'($urandom_range(3, 12)), 9'($urandom_range(0, 16)),
                        8'($urandom_range(0, 20)), 24);
    test_random_buffers(8'd0, 9'd3, 8'd1, 24);
    test_random_buffers(8'($urandom_range(3, 255)), 9'($urandom_range(0, 256)),
                        8'($urandom_range(0, 255)), 24);
    test_random_buffers(8'd4, 9'd511, 8'd128, 24);
    test_random_buffers(8'($urandom_range(3, 9)), 9'd1, 8'd0, 24);

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && predicted_out_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ebpl_pkg.sv
sv/ebpl_front.sv
sv/ebpl_queue.sv
sv/ebpl_back.sv
sv/escape_byte_patch_list_encoder_core.sv
verif/tb_top.sv
